### hdl/svg_pkg.sv
// ----------------------------------------------------------------------------
// Supply voltage guard package
// Shared types, register indexes and reset values of the supply voltage guard.
// ----------------------------------------------------------------------------
package svg_pkg;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;
  localparam int unsigned DtW      = 6;
  localparam int unsigned TimeW    = 16;
  localparam int unsigned MvW      = 16;
  localparam int unsigned MaW      = 16;
  localparam int unsigned RunW     = 8;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_POLL_INTERVAL = 3'd0,
    CFG_STARTUP_DELAY = 3'd1,
    CFG_WARN_MV       = 3'd2,
    CFG_CRITICAL_MV   = 3'd3,
    CFG_CRITICAL_CNT  = 3'd4
  } cfg_idx_e;

  localparam logic [TimeW-1:0] PollIntervalRst = 16'd250;
  localparam logic [TimeW-1:0] StartupDelayRst = 16'd1000;
  localparam logic [MvW-1:0]   WarnMvRst       = 16'd6500;
  localparam logic [MvW-1:0]   CriticalMvRst   = 16'd6000;
  localparam logic [RunW-1:0]  CriticalCntRst  = 8'd3;
  localparam logic [TimeW-1:0] TimeMax         = '1;
  localparam logic [RunW-1:0]  RunMax          = '1;

  typedef struct packed {
    logic [TimeW-1:0] poll_interval_ms;
    logic [TimeW-1:0] startup_delay_ms;
    logic [MvW-1:0]   warn_mv;
    logic [MvW-1:0]   critical_mv;
    logic [RunW-1:0]  critical_count;
  } cfg_t;

  typedef struct packed {
    logic [DtW-1:0] dt_ms;
    logic           link_up;
    logic           relay_on;
    logic           relay_just_switched;
    logic           voltage_read_ok;
    logic [MvW-1:0] voltage_in_mv;
    logic           current_read_ok;
    logic [MaW-1:0] current_in_ma;
  } item_t;

  typedef struct packed {
    logic           shutdown_request;
    logic           warning_flag;
    logic           critical_flag;
    logic           poll_fired;
    logic           voltage_updated;
    logic [MvW-1:0] voltage_mv;
    logic           voltage_held;
    logic           current_updated;
    logic [MaW-1:0] current_ma;
    logic           current_held;
  } result_t;

  typedef struct packed {
    logic critical_latched;
    logic warning_active;
  } guard_status_t;

endpackage

### hdl/svg_cfg_regs.sv
// ----------------------------------------------------------------------------
// Supply voltage guard configuration registers
// Holds the five thresholds and intervals written through the write port.
// ----------------------------------------------------------------------------
module svg_cfg_regs
  import svg_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  output cfg_t                cfg_o
);

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_POLL_INTERVAL: cfg_d.poll_interval_ms = cfg_wdata_i;
        CFG_STARTUP_DELAY: cfg_d.startup_delay_ms = cfg_wdata_i;
        CFG_WARN_MV:       cfg_d.warn_mv          = cfg_wdata_i;
        CFG_CRITICAL_MV:   cfg_d.critical_mv      = cfg_wdata_i;
        CFG_CRITICAL_CNT:  cfg_d.critical_count   = cfg_wdata_i[RunW-1:0];
        default:           cfg_d                  = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.poll_interval_ms <= PollIntervalRst;
      cfg_q.startup_delay_ms <= StartupDelayRst;
      cfg_q.warn_mv          <= WarnMvRst;
      cfg_q.critical_mv      <= CriticalMvRst;
      cfg_q.critical_count   <= CriticalCntRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

### hdl/svg_guard.sv
// ----------------------------------------------------------------------------
// Supply voltage guard core
// Timer, poll and threshold state, and the next result for one tick.
// ----------------------------------------------------------------------------
module svg_guard
  import svg_pkg::*;
(
  input  logic          clk_i,
  input  logic          rst_ni,
  input  cfg_t          cfg_i,
  input  logic          step_i,
  input  item_t         item_i,
  output result_t       result_o,
  output guard_status_t status_o
);

  logic [TimeW-1:0] relay_time_q, relay_time_d;
  logic [TimeW-1:0] poll_timer_q, poll_timer_d;
  logic [RunW-1:0]  run_q, run_d;
  logic             warn_q, warn_d;
  logic             crit_q, crit_d;
  logic [MvW-1:0]   held_v_q, held_v_d;
  logic             held_v_ok_q, held_v_ok_d;
  logic [MaW-1:0]   held_c_q, held_c_d;
  logic             held_c_ok_q, held_c_ok_d;
  logic             fired, v_upd, c_upd, shutdown;

  always_comb begin
    logic [TimeW:0]  rt_sum;
    logic [TimeW:0]  pt_sum;
    logic [RunW-1:0] run_inc;
    logic            armed;

    relay_time_d = relay_time_q;
    poll_timer_d = poll_timer_q;
    run_d        = run_q;
    warn_d       = warn_q;
    crit_d       = crit_q;
    held_v_d     = held_v_q;
    held_v_ok_d  = held_v_ok_q;
    held_c_d     = held_c_q;
    held_c_ok_d  = held_c_ok_q;
    fired        = 1'b0;
    v_upd        = 1'b0;
    c_upd        = 1'b0;
    shutdown     = 1'b0;
    armed        = 1'b0;
    run_inc      = '0;
    rt_sum       = '0;
    pt_sum       = '0;

    if (item_i.relay_just_switched) begin
      relay_time_d = '0;
      run_d        = '0;
      warn_d       = 1'b0;
    end

    if (item_i.link_up && !crit_q) begin
      if (item_i.relay_on) begin
        rt_sum       = {1'b0, relay_time_d} + {{(TimeW+1-DtW){1'b0}}, item_i.dt_ms};
        relay_time_d = rt_sum[TimeW] ? TimeMax : rt_sum[TimeW-1:0];
      end else begin
        relay_time_d = '0;
        run_d        = '0;
        warn_d       = 1'b0;
      end

      pt_sum       = {1'b0, poll_timer_q} + {{(TimeW+1-DtW){1'b0}}, item_i.dt_ms};
      poll_timer_d = pt_sum[TimeW] ? TimeMax : pt_sum[TimeW-1:0];

      if (poll_timer_d >= cfg_i.poll_interval_ms) begin
        poll_timer_d = '0;
        fired        = 1'b1;

        if (item_i.voltage_read_ok) begin
          armed       = item_i.relay_on && (relay_time_d >= cfg_i.startup_delay_ms);
          held_v_d    = item_i.voltage_in_mv;
          held_v_ok_d = 1'b1;
          v_upd       = 1'b1;
          warn_d      = armed && (item_i.voltage_in_mv < cfg_i.warn_mv);
          if (armed && (item_i.voltage_in_mv < cfg_i.critical_mv)) begin
            run_inc = (run_d == RunMax) ? run_d : run_d + 1'b1;
            run_d   = run_inc;
            if (run_inc >= cfg_i.critical_count) begin
              crit_d = 1'b1;
              warn_d = 1'b0;
            end
          end else begin
            run_d = '0;
          end
        end

        if (item_i.current_read_ok) begin
          held_c_d    = item_i.current_in_ma;
          held_c_ok_d = 1'b1;
          c_upd       = 1'b1;
        end
        shutdown = crit_d;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      relay_time_q <= '0;
      poll_timer_q <= TimeMax;
      run_q        <= '0;
      warn_q       <= 1'b0;
      crit_q       <= 1'b0;
      held_v_q     <= '0;
      held_v_ok_q  <= 1'b0;
      held_c_q     <= '0;
      held_c_ok_q  <= 1'b0;
    end else if (step_i) begin
      relay_time_q <= relay_time_d;
      poll_timer_q <= poll_timer_d;
      run_q        <= run_d;
      warn_q       <= warn_d;
      crit_q       <= crit_d;
      held_v_q     <= held_v_d;
      held_v_ok_q  <= held_v_ok_d;
      held_c_q     <= held_c_d;
      held_c_ok_q  <= held_c_ok_d;
    end
  end

  always_comb begin
    result_o.shutdown_request = shutdown;
    result_o.warning_flag     = warn_d;
    result_o.critical_flag    = crit_d;
    result_o.poll_fired       = fired;
    result_o.voltage_updated  = v_upd;
    result_o.voltage_mv       = held_v_d;
    result_o.voltage_held     = held_v_ok_d;
    result_o.current_updated  = c_upd;
    result_o.current_ma       = held_c_d;
    result_o.current_held     = held_c_ok_d;
  end

  assign status_o.critical_latched = crit_q;
  assign status_o.warning_active   = warn_q;

endmodule

### hdl/supply_voltage_guard_top.sv
// ----------------------------------------------------------------------------
// Supply voltage guard top level
// An accepted transaction is registered; its result goes to the result register.
// Throughput: one transaction per cycle unless stalled; state updates per step.
// The result register lets a new transaction enter while a result waits.
// Reset: asynchronous, active low; restores default registers and clears state,
// with the poll timer set to its maximum so that the first active tick polls.
// ----------------------------------------------------------------------------
module supply_voltage_guard_top
  import svg_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [DtW-1:0]      dt_ms_i,
  input  logic                link_up_i,
  input  logic                relay_on_i,
  input  logic                relay_just_switched_i,
  input  logic                voltage_read_ok_i,
  input  logic [MvW-1:0]      voltage_in_mv_i,
  input  logic                current_read_ok_i,
  input  logic [MaW-1:0]      current_in_ma_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic                shutdown_request_o,
  output logic                warning_flag_o,
  output logic                critical_flag_o,
  output logic                poll_fired_o,
  output logic                voltage_updated_o,
  output logic [MvW-1:0]      voltage_mv_o,
  output logic                voltage_held_o,
  output logic                current_updated_o,
  output logic [MaW-1:0]      current_ma_o,
  output logic                current_held_o
);

  cfg_t          cfg;
  item_t         item_q;
  logic          item_valid_q;
  result_t       result_d, result_q;
  logic          out_valid_q;
  logic          step;
  logic          in_accept;
  guard_status_t status;

  svg_cfg_regs u_cfg_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  svg_guard u_guard (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg),
    .step_i   (step),
    .item_i   (item_q),
    .result_o (result_d),
    .status_o (status)
  );

  assign step       = item_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = item_valid_q && !step;
  assign in_accept  = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (in_accept) begin
        item_valid_q <= 1'b1;
      end else if (step) begin
        item_valid_q <= 1'b0;
      end
      if (step) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      item_q.dt_ms               <= dt_ms_i;
      item_q.link_up             <= link_up_i;
      item_q.relay_on            <= relay_on_i;
      item_q.relay_just_switched <= relay_just_switched_i;
      item_q.voltage_read_ok     <= voltage_read_ok_i;
      item_q.voltage_in_mv       <= voltage_in_mv_i;
      item_q.current_read_ok     <= current_read_ok_i;
      item_q.current_in_ma       <= current_in_ma_i;
    end
    if (step) begin
      result_q <= result_d;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign shutdown_request_o = result_q.shutdown_request;
  assign warning_flag_o     = result_q.warning_flag;
  assign critical_flag_o    = result_q.critical_flag;
  assign poll_fired_o       = result_q.poll_fired;
  assign voltage_updated_o  = result_q.voltage_updated;
  assign voltage_mv_o       = result_q.voltage_mv;
  assign voltage_held_o     = result_q.voltage_held;
  assign current_updated_o  = result_q.current_updated;
  assign current_ma_o       = result_q.current_ma;
  assign current_held_o     = result_q.current_held;

  a_crit_sticky : assert property (@(posedge clk_i) disable iff (!rst_ni)
    status.critical_latched |=> status.critical_latched)
    else $error("Critical latch cleared without reset.");

  a_warn_crit_excl : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(status.critical_latched && status.warning_active))
    else $error("Warning active while critical state is latched.");

  a_shutdown_poll : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && shutdown_request_o) |-> (poll_fired_o && critical_flag_o))
    else $error("Shutdown request without a poll and a latched critical state.");

  a_step_clears : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step && !in_accept) |=> !in_stall_o)
    else $error("Input stage still full after its transaction moved on.");

endmodule
